FILE: sv/lsq_pkg.sv
// lsq_pkg: shared types and constants for the largest square of ones block
// register map, square size width and size helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsq_pkg;

  // width of a square side, a size register and the result
  localparam int unsigned SIZE_W = 11;

  // configuration data and address widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  typedef logic [SIZE_W-1:0] size_t;

  // register indexes, decoded from the word address
  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_e;

  localparam size_t SIZE_MAX = {SIZE_W{1'b1}};

  // min of three sizes plus one, saturating at the largest size
  function automatic size_t grow_size(size_t up, size_t left, size_t diag);
    size_t              m;
    logic [SIZE_W:0]    s;
    m = (up < left) ? up : left;
    m = (m < diag) ? m : diag;
    s = {1'b0, m} + {{SIZE_W{1'b0}}, 1'b1};
    grow_size = s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/lsq_line_buf.sv
// lsq_line_buf: line buffer holding the previous row's square sizes
// one write port and one read port, read data registered
// depends on lsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsq_line_buf #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire                  clk_i,
  input  wire                  rd_en_i,
  input  wire [ADDR_W-1:0]     rd_addr_i,
  output lsq_pkg::size_t       rd_data_o,
  input  wire                  wr_en_i,
  input  wire [ADDR_W-1:0]     wr_addr_i,
  input  wire lsq_pkg::size_t  wr_data_i
);

  lsq_pkg::size_t mem [DEPTH];
  lsq_pkg::size_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/largest_square_of_ones.sv
// largest_square_of_ones: side of the largest all-ones square in a binary frame
// two-stage pipeline around a line buffer of previous-row sizes
// depends on lsq_pkg and lsq_line_buf
`timescale 1ns / 1ps
`default_nettype none

//  channel        | direction | handshake                          | payload
//  ---------------+-----------+------------------------------------+------------------------
//  pixel          | in        | pixel_valid_i / pixel_ready_o      | pixel_i (1 bit)
//  largest_side   | out       | largest_side_valid_o / _ready_i    | largest_side_o (11 bits)
//  configuration  | in        | apb: psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  one pixel per cycle sustained while no result waits; a frame result is presented once the
//  frame's last pixel has passed the stage 1 registers: the line buffer read is issued at intake
//  and the size stage writes the entry back and loads the output register
//  reset clears counters, neighbour registers, best size and pipeline valids; the line
//  buffer has no reset and an entry's read value is only used after the previous row wrote it
//  a result waiting in the output register stalls intake only when the next
//  frame's last pixel reaches the size stage

module largest_square_of_ones #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // pixel stream
  input  wire                          pixel_i,
  input  wire                          pixel_valid_i,
  output logic                         pixel_ready_o,
  // result
  output lsq_pkg::size_t               largest_side_o,
  output logic                         largest_side_valid_o,
  input  wire                          largest_side_ready_i,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [lsq_pkg::ADDR_W-1:0]    paddr,
  input  wire [lsq_pkg::DATA_W-1:0]    pwdata,
  output logic [lsq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  lsq_pkg::size_t row_count_q, column_count_q;
  lsq_pkg::reg_idx_e reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = lsq_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= lsq_pkg::size_t'(1);
      column_count_q <= lsq_pkg::size_t'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        lsq_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[lsq_pkg::SIZE_W-1:0];
        lsq_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[lsq_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lsq_pkg::REG_ROW_COUNT:    prdata = lsq_pkg::DATA_W'(row_count_q);
      lsq_pkg::REG_COLUMN_COUNT: prdata = lsq_pkg::DATA_W'(column_count_q);
      default:                   prdata = '0;
    endcase
  end

  // zero counts as one, anything above the buffer limit saturates
  logic [31:0] rows_eff, cols_eff;

  always_comb begin
    rows_eff = 32'(row_count_q);
    if (rows_eff == 32'd0) begin
      rows_eff = 32'd1;
    end else if (rows_eff > MAX_ROWS) begin
      rows_eff = MAX_ROWS;
    end
    cols_eff = 32'(column_count_q);
    if (cols_eff == 32'd0) begin
      cols_eff = 32'd1;
    end else if (cols_eff > MAX_COLUMNS) begin
      cols_eff = MAX_COLUMNS;
    end
  end

  // ------------------------------------------------------------------
  // stage 0: position counters, line buffer read issued on intake
  // ------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          in_xfer;
  logic          last_col, last_row;

  assign in_xfer  = pixel_valid_i && pixel_ready_o;
  assign last_col = (32'(col_q) + 32'd1) >= cols_eff;
  assign last_row = (32'(row_q) + 32'd1) >= rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: size from up, left and diagonal, written back to the buffer
  // ------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_pix_q;
  logic          s1_edge_q;      // first row or first column
  logic          s1_last_col_q;
  logic          s1_frame_end_q;
  logic [CW-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pixel_ready_o) begin
      s1_valid_q <= pixel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q       <= pixel_i;
      s1_edge_q      <= (row_q == '0) || (col_q == '0);
      s1_last_col_q  <= last_col;
      s1_frame_end_q <= last_col && last_row;
      s1_col_q       <= col_q;
    end
  end

  lsq_pkg::size_t up_size;
  lsq_pkg::size_t left_q, diag_q, best_q;
  lsq_pkg::size_t size_d, best_d;
  logic           s1_go;
  logic           out_valid_q;
  lsq_pkg::size_t out_q;

  // a finished frame may not overwrite a result that is still waiting
  assign s1_go = s1_valid_q &&
                 !(s1_frame_end_q && out_valid_q && !largest_side_ready_i);
  assign pixel_ready_o = !s1_valid_q || s1_go;

  // the read for the pixel now in stage 1 was issued at its intake; a write
  // to the same entry in that cycle only happens with one column, where the
  // up value is never used
  lsq_line_buf #(
    .DEPTH  (MAX_COLUMNS),
    .ADDR_W (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (up_size),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (size_d)
  );

  always_comb begin
    if (s1_edge_q) begin
      size_d = lsq_pkg::size_t'(s1_pix_q);
    end else if (s1_pix_q) begin
      size_d = lsq_pkg::grow_size(up_size, left_q, diag_q);
    end else begin
      size_d = '0;
    end
    best_d = (size_d > best_q) ? size_d : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      diag_q <= '0;
      best_q <= '0;
    end else if (s1_go) begin
      // neighbours restart at every row end
      left_q <= s1_last_col_q ? '0 : size_d;
      diag_q <= s1_last_col_q ? '0 : up_size;
      best_q <= s1_frame_end_q ? '0 : best_d;
    end
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_frame_end_q) begin
      out_valid_q <= 1'b1;
    end else if (largest_side_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_frame_end_q) begin
      out_q <= best_d;
    end
  end

  assign largest_side_o       = out_q;
  assign largest_side_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking bench for largest_square_of_ones, pixel stream in, square side out
// predicts each frame result from its own scan of the pixels and compares at the output
// depends on lsq_pkg and the largest_square_of_ones rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned COLUMN_LIMIT = 1024;
  localparam int unsigned ROW_LIMIT    = 1024;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  // idle wait on top of the drain, after every pixel is taken and every side has come out
  localparam int unsigned DRAIN_CYCLES = 8;

  // output side stall patterns
  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_pattern_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every block input has a known value from time zero
  logic                        pixel_i              = 1'b0;
  logic                        pixel_valid_i        = 1'b0;
  logic                        largest_side_ready_i = 1'b0;
  logic                        psel                 = 1'b0;
  logic                        penable              = 1'b0;
  logic                        pwrite               = 1'b0;
  logic [lsq_pkg::ADDR_W-1:0]  paddr                = '0;
  logic [lsq_pkg::DATA_W-1:0]  pwdata               = '0;

  wire                         pixel_ready_o;
  lsq_pkg::size_t              largest_side_o;
  wire                         largest_side_valid_o;
  wire  [lsq_pkg::DATA_W-1:0]  prdata;
  wire                         pready;

  // pixels waiting to be offered, and frame sides still owed by the block
  logic           pixels_pending[$];
  lsq_pkg::size_t largest_side_due[$];

  // shadow of the size registers as last written
  lsq_pkg::size_t cfg_rows = lsq_pkg::size_t'(1);
  lsq_pkg::size_t cfg_cols = lsq_pkg::size_t'(1);

  // own copy of the scan state
  lsq_pkg::size_t row_sizes[COLUMN_LIMIT];
  lsq_pkg::size_t left_sz  = '0;
  lsq_pkg::size_t diag_sz  = '0;
  lsq_pkg::size_t best_sz  = '0;
  int unsigned    row_idx  = 0;
  int unsigned    col_idx  = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // long receiver hold-off, asked for by the stimulus and counted by the receiver
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;

  // sender burst shaping and receiver pattern state
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  rx_pattern_e stall_mode = RX_OPEN;

  largest_square_of_ones #(
    .MAX_COLUMNS (COLUMN_LIMIT),
    .MAX_ROWS    (ROW_LIMIT)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .pixel_i              (pixel_i),
    .pixel_valid_i        (pixel_valid_i),
    .pixel_ready_o        (pixel_ready_o),
    .largest_side_o       (largest_side_o),
    .largest_side_valid_o (largest_side_valid_o),
    .largest_side_ready_i (largest_side_ready_i),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame extent as the block sees it: zero reads as one, too large saturates
  function automatic int unsigned frame_extent(input lsq_pkg::size_t v,
                                               input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // advance the square scan by one pixel; returns 1 when the pixel closes a frame,
  // with the frame's largest side in side
  function automatic bit scan_pixel(input logic pix, output lsq_pkg::size_t side);
    lsq_pkg::size_t up;
    lsq_pkg::size_t sz;
    lsq_pkg::size_t m;
    bit             done;
    up = row_sizes[col_idx];
    if (row_idx == 0 || col_idx == 0) begin
      // first row or first column: the pixel stands alone
      sz = lsq_pkg::size_t'(pix);
    end else if (pix) begin
      m = (up < left_sz) ? up : left_sz;
      if (diag_sz < m) m = diag_sz;
      sz = (m == lsq_pkg::SIZE_MAX) ? lsq_pkg::SIZE_MAX : m + lsq_pkg::size_t'(1);
    end else begin
      sz = '0;
    end
    if (sz > best_sz) best_sz = sz;
    diag_sz = up;
    row_sizes[col_idx] = sz;
    left_sz = sz;
    side = best_sz;
    done = 1'b0;
    if (col_idx + 1 < frame_extent(cfg_cols, COLUMN_LIMIT)) begin
      col_idx++;
    end else begin
      // end of row: neighbours restart at the left edge
      col_idx = 0;
      left_sz = '0;
      diag_sz = '0;
      if (row_idx + 1 >= frame_extent(cfg_rows, ROW_LIMIT)) begin
        done    = 1'b1;
        row_idx = 0;
        best_sz = '0;
      end else begin
        row_idx++;
      end
    end
    return done;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // driver: offers queued pixels in bursts, runs the prediction on each transaction
  always @(posedge clk_i) begin
    lsq_pkg::size_t side;
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
    end else begin
      if (pixel_valid_i && pixel_ready_o) begin
        if (scan_pixel(pixel_i, side)) largest_side_due.push_back(side);
      end
      // free to offer the next pixel once the current one is taken
      if (!pixel_valid_i || pixel_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          pixel_valid_i <= 1'b0;
        end else if (pixels_pending.size() != 0) begin
          pixel_valid_i <= 1'b1;
          pixel_i       <= pixels_pending.pop_front();
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          // half the bursts run straight into the next one
          if (burst_left == 0) gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: a long hold-off on request, otherwise stretches of varying stall patterns
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      largest_side_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      largest_side_ready_i <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken++;
      hold_left = HOLD_CYCLES;
      largest_side_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_pattern_e'($urandom_range(0, 3));
        stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
        RX_OPEN:   largest_side_ready_i <= 1'b1;
        RX_HALF:   largest_side_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: largest_side_ready_i <= ($urandom_range(0, 4) == 0);
        default:   largest_side_ready_i <= stall_left[0];
      endcase
    end
  end

  // monitor: each result transaction against the oldest expected side
  always @(posedge clk_i) begin
    lsq_pkg::size_t want;
    if (rst_ni && largest_side_valid_o && largest_side_ready_i) begin
      if (largest_side_due.size() == 0) begin
        report_mismatch($sformatf("largest side %0d with none expected", largest_side_o));
      end else begin
        want = largest_side_due.pop_front();
        if (largest_side_o !== want)
          report_mismatch($sformatf("largest side %0d, expected %0d", largest_side_o, want));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // apb write: setup cycle, then access cycle held until pready
  task automatic write_reg(input lsq_pkg::reg_idx_e idx,
                           input logic [lsq_pkg::DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lsq_pkg::REG_ROW_COUNT) cfg_rows = value[lsq_pkg::SIZE_W-1:0];
    else cfg_cols = value[lsq_pkg::SIZE_W-1:0];
  endtask

  // sender pauses until every pixel is taken and every side has come out
  task automatic wait_drained();
    while (pixels_pending.size() != 0 || pixel_valid_i || largest_side_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // frame size is only changed with the block idle and at a frame boundary
  task automatic set_frame_size(input logic [lsq_pkg::DATA_W-1:0] rows,
                                input logic [lsq_pkg::DATA_W-1:0] cols);
    wait_drained();
    write_reg(lsq_pkg::REG_ROW_COUNT, rows);
    write_reg(lsq_pkg::REG_COLUMN_COUNT, cols);
  endtask

  // directed pixels, first pixel in the top bit
  function automatic void push_bits(input logic [15:0] bits, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) pixels_pending.push_back(bits[i]);
  endfunction

  // one random frame at the current size; density is the percentage of set pixels
  function automatic int unsigned push_frame(input int unsigned density);
    int unsigned n;
    n = frame_extent(cfg_rows, ROW_LIMIT) * frame_extent(cfg_cols, COLUMN_LIMIT);
    for (int unsigned i = 0; i < n; i++)
      pixels_pending.push_back($urandom_range(0, 99) < density);
    return n;
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned random_frames;
    int unsigned rows;
    int unsigned cols;
    int unsigned density;

    random_items  = 0;
    random_frames = 0;
    foreach (row_sizes[i]) row_sizes[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size is one by one: a clear then a set pixel
    push_bits(16'b01, 2);
    // zero in both size registers still means one by one
    set_frame_size(0, 0);
    push_bits(16'b1, 1);
    // two by two, full square then one with a hole at the corner
    set_frame_size(2, 2);
    push_bits(16'b1111_1101, 8);
    // three by three, square of two away from the corner, last pixel clear
    set_frame_size(3, 3);
    push_bits(16'b011_111_110, 9);

    // single-pixel frames with the receiver held off: output register fills
    // and the pixel input stalls while the sender keeps offering
    set_frame_size(1, 1);
    hold_asked++;
    repeat (40) void'(push_frame(50));

    // a tall single column, then long rows through a wide stretch of the buffer
    set_frame_size(64, 1);
    void'(push_frame(97));
    set_frame_size(2, 100);
    void'(push_frame(97));

    // random sizes and densities, a few frames per size setting
    while (random_items < 230 || random_frames < 10) begin
      rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_frame_size(rows, cols);
      repeat ($urandom_range(1, 3)) begin
        // mostly dense frames so that large squares build up
        density = ($urandom_range(0, 1) == 0) ? 100 - $urandom_range(0, 15)
                                              : $urandom_range(0, 100);
        random_items += push_frame(density);
        random_frames++;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
